>>> hw/rtl/lcf_pkg.sv
// Shared types and constants for the LCD serial framer.
package lcf_pkg;

    localparam int MAX_NIBBLES = 4;

    localparam int HDR_BITS = 9;
    localparam int CMD_BITS = 12;
    localparam int DATA_W   = 4 * MAX_NIBBLES;
    localparam int FRAME_W  = HDR_BITS + DATA_W;
    localparam int LEN_W    = $clog2(FRAME_W + 1);
    localparam int CNT_W    = $clog2(MAX_NIBBLES + 1);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [3:0] CMD_PREFIX = 4'b1000;
    localparam logic [2:0] WRITE_ID   = 3'b101;

    localparam logic KIND_CMD   = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] bits;   // MSB goes out first
        logic [LEN_W-1:0]   len;
    } frame_t;

endpackage

>>> hw/rtl/lcf_front.sv
// Front end: accepts request words and builds the frame bit vector and length.
module lcf_front
    import lcf_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 q_full,
    output logic                 push,
    output frame_t               push_frame
);

    logic [7:0]        command_code;
    logic [4:0]        address;
    logic [2:0]        nibble_count;
    logic [15:0]       nibbles;
    logic [3:0]        dot_bits;
    logic [DATA_W-1:0] data_ext;
    logic [DATA_W-1:0] data_msb;
    logic [CNT_W-1:0]  cnt_sat;

    assign command_code = s_tdata[7:0];
    assign address      = s_tdata[12:8];
    assign nibble_count = s_tdata[15:13];
    assign nibbles      = s_tdata[31:16];
    assign dot_bits     = s_tdata[35:32];

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // nibbles past the 16-bit field read as zero
    assign data_ext = DATA_W'(nibbles);

    always_comb begin
        data_msb = '0;
        for (int i = 0; i < MAX_NIBBLES; i++) begin
            data_msb[DATA_W-1-4*i -: 4] = data_ext[4*i +: 4];
        end
        data_msb[DATA_W-1 -: 4] = data_msb[DATA_W-1 -: 4] | dot_bits;
    end

    always_comb begin
        priority if (nibble_count == 3'd0) begin
            cnt_sat = CNT_W'(1);
        end else if (32'(nibble_count) > MAX_NIBBLES) begin
            cnt_sat = CNT_W'(MAX_NIBBLES);
        end else begin
            cnt_sat = CNT_W'(nibble_count);
        end
    end

    always_comb begin
        push_frame = '0;
        unique case (s_tuser)
            KIND_CMD: begin
                push_frame.bits[FRAME_W-1 -: CMD_BITS] = {CMD_PREFIX, command_code};
                push_frame.len = LEN_W'(CMD_BITS);
            end
            KIND_WRITE: begin
                push_frame.bits = {WRITE_ID, 1'b0, address, data_msb};
                push_frame.len  = LEN_W'(HDR_BITS) + LEN_W'({cnt_sat, 2'b00});
            end
            default: begin
                push_frame = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/lcf_queue.sv
// Two-entry queue of built frames between front and back end.
module lcf_queue
    import lcf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output frame_t head
);

    frame_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

>>> hw/rtl/lcf_back.sv
// Back end: shifts one frame out a bit per word, MSB first, marking the last bit.
module lcf_back
    import lcf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  frame_t               q_head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic [FRAME_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic               fire;
    logic               final_bit;

    assign fire      = m_tvalid && m_tready;
    assign final_bit = left_reg == LEN_W'(1);
    assign pop       = q_not_empty && (left_reg == '0 || (fire && final_bit));

    assign m_tvalid = left_reg != '0;
    assign m_tdata  = M_TDATA_W'(shift_reg[FRAME_W-1]);
    assign m_tlast  = final_bit;

    always_comb begin
        shift_next = shift_reg;
        left_next  = left_reg;
        priority if (pop) begin
            shift_next = q_head.bits;
            left_next  = q_head.len;
        end else if (fire) begin
            shift_next = {shift_reg[FRAME_W-2:0], 1'b0};
            left_next  = left_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

endmodule

>>> hw/rtl/lcd_controller_serial_framer.sv
// Top level of the three-wire LCD serial framer.
// The request word is registered in the frame queue, then loaded into the back end shift register.
// Throughput: one bit per cycle while m_tready is high; a frame is 12 bits (command) or
// 9 + 4 * nibble count bits (write), with the nibble count clamped to 1..4.
// A two-entry frame queue lets requests be taken while a frame is shifting out.
// Reset (aresetn low, synchronous) empties the queue and drops any frame in flight.
module lcd_controller_serial_framer
    import lcf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] command_code, [12:8] address, [15:13] nibble_count,
    // [31:16] nibbles, [35:32] dot_bits, [39:36] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] kind
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] serial_bit, [7:1] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic   q_full;
    logic   q_not_empty;
    logic   push;
    logic   pop;
    frame_t push_frame;
    frame_t q_head;

    lcf_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push       (push),
        .push_frame (push_frame)
    );

    lcf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    lcf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

>>> hw/rtl/lcf_checker.sv
// Port-level checks for the LCD serial framer, bound to the top level.
module lcf_checker
    import lcf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request word changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("padding bits of result word not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

endmodule

bind lcd_controller_serial_framer lcf_checker u_lcf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> sim/tb_lcd_controller_serial_framer.sv
// Testbench for the LCD serial framer: directed and random requests, per-bit checking.
module tb_lcd_controller_serial_framer;
    import lcf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        logic [7:0]  command_code;
        logic [4:0]  address;
        logic [2:0]  nibble_count;
        logic [15:0] nibbles;
        logic [3:0]  dot_bits;
    } lcd_req_t;

    typedef struct {
        logic serial_bit;
        logic last_bit;
    } line_bit_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    line_bit_t expected_bits[$];
    line_bit_t bit_head;
    int        error_count = 0;

    // idling controls, changed per test
    bit gaps_on  = 1'b0;
    bit stall_on = 1'b0;
    int burst_left = 0;
    int ready_run = 0;

    lcd_controller_serial_framer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Build the frame, then queue it up bit by bit, MSB first.
    function automatic void predict_frame(input lcd_req_t r);
        logic [FRAME_W-1:0] frame;
        int                 len;
        int                 n_nib;
        logic [3:0]         nib;
        line_bit_t          b;
        if (r.kind == KIND_CMD) begin
            frame = FRAME_W'({CMD_PREFIX, r.command_code});
            len = CMD_BITS;
        end else begin
            n_nib = int'(r.nibble_count);
            if (n_nib < 1) n_nib = 1;
            if (n_nib > MAX_NIBBLES) n_nib = MAX_NIBBLES;
            frame = FRAME_W'({WRITE_ID, 1'b0, r.address});
            len = HDR_BITS;
            for (int i = 0; i < n_nib; i++) begin
                nib = (i < 4) ? r.nibbles[4*i +: 4] : 4'h0;
                if (i == 0) nib = nib | r.dot_bits;
                frame = (frame << 4) | FRAME_W'(nib);
                len += 4;
            end
        end
        for (int k = len - 1; k >= 0; k--) begin
            b.serial_bit = frame[k];
            b.last_bit = (k == 0);
            expected_bits.push_back(b);
        end
    endfunction

    // Called at a falling edge; returns at a falling edge after the word is taken.
    task automatic send_request(input lcd_req_t r);
        s_tdata = {4'b0000, r.dot_bits, r.nibbles, r.nibble_count, r.address,
                   r.command_code};
        s_tuser = r.kind;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_frame(r);
        @(negedge aclk);
        if (gaps_on && burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 8);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    function automatic lcd_req_t make_request(input logic kind, input logic [7:0] cmd,
                                              input logic [4:0] addr,
                                              input logic [2:0] cnt,
                                              input logic [15:0] nibs,
                                              input logic [3:0] dots);
        lcd_req_t r;
        r.kind = kind;
        r.command_code = cmd;
        r.address = addr;
        r.nibble_count = cnt;
        r.nibbles = nibs;
        r.dot_bits = dots;
        return r;
    endfunction

    task automatic test_command_frames();
        gaps_on = 1'b0;
        stall_on = 1'b0;
        // junk in the write fields must not leak into the frame
        send_request(make_request(KIND_CMD, 8'h00, 5'h1F, 3'd7, 16'hFFFF, 4'hF));
        send_request(make_request(KIND_CMD, 8'hFF, 5'h00, 3'd0, 16'h0000, 4'h0));
        send_request(make_request(KIND_CMD, 8'hA5, 5'h15, 3'd3, 16'h5A5A, 4'h9));
        send_request(make_request(KIND_CMD, 8'h5A, 5'h0A, 3'd4, 16'hA5A5, 4'h6));
    endtask

    task automatic test_write_frames();
        gaps_on = 1'b0;
        stall_on = 1'b1;
        send_request(make_request(KIND_WRITE, 8'hFF, 5'h00, 3'd1, 16'h0000, 4'h0));
        send_request(make_request(KIND_WRITE, 8'h00, 5'h1F, 3'd4, 16'hFFFF, 4'hF));
        send_request(make_request(KIND_WRITE, 8'h3C, 5'h11, 3'd2, 16'h1234, 4'h0));
        send_request(make_request(KIND_WRITE, 8'hC3, 5'h0E, 3'd3, 16'hABCD, 4'h0));
        send_request(make_request(KIND_WRITE, 8'h00, 5'h05, 3'd4, 16'h8421, 4'h0));
        // dots only touch the first nibble
        send_request(make_request(KIND_WRITE, 8'h00, 5'h02, 3'd4, 16'h0000, 4'hF));
        send_request(make_request(KIND_WRITE, 8'h00, 5'h03, 3'd2, 16'h0050, 4'hA));
    endtask

    task automatic test_nibble_count_saturation();
        gaps_on = 1'b1;
        stall_on = 1'b1;
        // zero count becomes one nibble
        send_request(make_request(KIND_WRITE, 8'h00, 5'h07, 3'd0, 16'hFED9, 4'h2));
        send_request(make_request(KIND_WRITE, 8'h00, 5'h18, 3'd0, 16'h0000, 4'h0));
        // counts above the maximum clamp
        send_request(make_request(KIND_WRITE, 8'h00, 5'h09, 3'd5, 16'h1357, 4'h8));
        send_request(make_request(KIND_WRITE, 8'h00, 5'h1C, 3'd6, 16'h2468, 4'h1));
        send_request(make_request(KIND_WRITE, 8'hFF, 5'h1F, 3'd7, 16'hFFFF, 4'hF));
    endtask

    task automatic test_random_requests(input int n_items, input bit with_gaps,
                                        input bit with_stalls);
        lcd_req_t r;
        gaps_on = with_gaps;
        stall_on = with_stalls;
        for (int i = 0; i < n_items; i++) begin
            r = make_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                             16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
            send_request(r);
        end
    endtask

    // receiver: always ready, or with stalls on, alternating ready and stall runs of random length
    always @(negedge aclk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else if (ready_run == 0) begin
            m_tready <= ~m_tready;
            ready_run = m_tready ? $urandom_range(1, 5) : $urandom_range(1, 10);
        end else begin
            ready_run--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bits.size() == 0) begin
                $error("output word with nothing expected: serial_bit=%0d last_bit=%0d",
                       m_tdata[0], m_tlast);
                error_count++;
            end else begin
                bit_head = expected_bits.pop_front();
                if (m_tdata[0] !== bit_head.serial_bit) begin
                    $error("serial_bit: expected %0d, got %0d",
                           bit_head.serial_bit, m_tdata[0]);
                    error_count++;
                end
                if (m_tlast !== bit_head.last_bit) begin
                    $error("last_bit: expected %0d, got %0d", bit_head.last_bit, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_command_frames();
        test_write_frames();
        test_nibble_count_saturation();
        test_random_requests(41, 1'b0, 1'b0);
        test_random_requests(41, 1'b1, 1'b0);
        test_random_requests(41, 1'b0, 1'b1);
        test_random_requests(41, 1'b1, 1'b1);

        s_tvalid = 1'b0;
        while (expected_bits.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lcf_pkg.sv
hw/rtl/lcf_front.sv
hw/rtl/lcf_queue.sv
hw/rtl/lcf_back.sv
hw/rtl/lcd_controller_serial_framer.sv
hw/rtl/lcf_checker.sv
sim/tb_lcd_controller_serial_framer.sv
